// ===== rtl/sstm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite slot table package
// Shared widths, mode codes, attribute constants and control structs.
// ----------------------------------------------------------------------------
package sstm_pkg;

    localparam int DEFAULT_SLOTS = 128;
    localparam int MODE_W        = 3;
    localparam int SLOT_W        = 7;
    localparam int WORD_W        = 16;
    localparam int POSX_W        = 9;
    localparam int POSY_W        = 8;
    localparam int TILE_W        = 10;
    localparam int SCAN_W        = 32;
    localparam int SCAN_OFF_W    = 5;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HIDE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHOW  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

    localparam logic [WORD_W-1:0] HIDE_BIT = 16'h0200;
    localparam logic [WORD_W-1:0] PRIO_ONE = 16'h0400;

    typedef struct packed {
        logic clear;
        logic accept;
        logic scan;
        logic finish;
    } sstm_cmd_t;

    typedef struct packed {
        logic req_alloc;
        logic clear_last;
        logic scan_hit;
        logic scan_last;
    } sstm_stat_t;

endpackage

// ===== rtl/sstm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sprite slot table controller
// Sequences the clearing pass, free map scan, read-modify-write and output.
// ----------------------------------------------------------------------------
module sstm_ctrl
    import sstm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  sstm_stat_t stat,
    output sstm_cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_MODIFY = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.req_alloc ? S_SCAN : S_MODIFY;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit || stat.scan_last)
                begin
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_direct_to_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !stat.req_alloc) |=> (state_reg == S_MODIFY))
        else $error("non-allocate transaction did not go straight to modify");

    a_no_output_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result presented during clearing pass");

endmodule

// ===== rtl/sstm_datapath.sv =====
// ----------------------------------------------------------------------------
// Sprite slot table datapath
// Free map with grouped lowest-free scan, attribute memory and result registers.
// ----------------------------------------------------------------------------
module sstm_datapath
    import sstm_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sstm_cmd_t         cmd,
    output sstm_stat_t        stat,
    input  logic [MODE_W-1:0] mode,
    input  logic [SLOT_W-1:0] slot,
    input  logic [POSX_W-1:0] pos_x,
    input  logic [POSY_W-1:0] pos_y,
    input  logic [TILE_W-1:0] tile,
    input  logic [WORD_W-1:0] size_word,
    output logic              status,
    output logic [SLOT_W-1:0] granted_slot,
    output logic [WORD_W-1:0] word0,
    output logic [WORD_W-1:0] word1,
    output logic [WORD_W-1:0] word2
);

    localparam int AW      = $clog2(SLOTS);
    localparam int NGROUPS = (SLOTS + SCAN_W - 1) / SCAN_W;
    localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int PADW    = NGROUPS * SCAN_W;
    localparam int ENTRY_W = 3 * WORD_W;
    localparam logic [ENTRY_W-1:0] RESET_ENTRY = {HIDE_BIT, {(2 * WORD_W){1'b0}}};

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [SLOTS-1:0]   free_reg;
    logic [PADW-1:0]    free_pad;
    logic [SCAN_W-1:0]  group_bits;
    logic [SCAN_OFF_W-1:0] group_off;
    logic [AW-1:0]      found_idx;
    logic [GW-1:0]      grp_reg;
    logic [AW-1:0]      clr_reg;
    logic               blank_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [POSX_W-1:0]  pos_x_reg;
    logic [POSY_W-1:0]  pos_y_reg;
    logic [TILE_W-1:0]  tile_reg;
    logic [WORD_W-1:0]  size_reg;
    logic [AW-1:0]      addr_reg;
    logic [SLOT_W-1:0]  granted_reg;
    logic               status_reg;
    logic               out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [WORD_W-1:0]  word0_reg;
    logic [WORD_W-1:0]  word1_reg;
    logic [WORD_W-1:0]  word2_reg;

    logic [AW-1:0]      slot_idx;
    logic               slot_oob;
    logic               scan_hit;
    logic               scan_last;
    logic               mem_re;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [WORD_W-1:0]  new0;
    logic [WORD_W-1:0]  new1;
    logic [WORD_W-1:0]  new2;

    assign slot_idx = AW'(slot);
    assign slot_oob = (32'(slot) >= 32'(SLOTS));

    always_comb
    begin
        free_pad = '0;
        free_pad[SLOTS-1:0] = free_reg;
    end

    assign group_bits = free_pad[grp_reg * SCAN_W +: SCAN_W];

    always_comb
    begin
        group_off = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (group_bits[i])
            begin
                group_off = SCAN_OFF_W'(i);
            end
        end
    end

    assign found_idx = AW'({grp_reg, group_off});
    assign scan_hit  = |group_bits;
    assign scan_last = (grp_reg == GW'(NGROUPS - 1));

    assign stat.req_alloc  = (mode == MODE_ALLOC);
    assign stat.clear_last = (clr_reg == AW'(SLOTS - 1));
    assign stat.scan_hit   = scan_hit;
    assign stat.scan_last  = scan_last;

    always_comb
    begin
        new0 = rd_data_reg[3*WORD_W-1:2*WORD_W];
        new1 = rd_data_reg[2*WORD_W-1:WORD_W];
        new2 = rd_data_reg[WORD_W-1:0];
        case (mode_reg)
            MODE_FREE, MODE_HIDE:
            begin
                new0 = new0 | HIDE_BIT;
            end
            MODE_SET:
            begin
                new0 = WORD_W'(pos_y_reg);
                new1 = WORD_W'(pos_x_reg) | size_reg;
                new2 = WORD_W'(tile_reg) | PRIO_ONE;
            end
            MODE_SHOW:
            begin
                new0 = new0 & ~HIDE_BIT;
            end
            default:
            begin
            end
        endcase
    end

    assign mem_re  = cmd.accept || (cmd.scan && scan_hit);
    assign rd_addr = cmd.accept ? slot_idx : found_idx;
    assign mem_we  = cmd.clear || (cmd.finish && !blank_reg);
    assign wr_addr = cmd.clear ? clr_reg : addr_reg;
    assign wr_data = cmd.clear ? RESET_ENTRY : {new0, new1, new2};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= '1;
            grp_reg   <= '0;
            clr_reg   <= '0;
            blank_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                grp_reg   <= '0;
                blank_reg <= slot_oob && (mode != MODE_ALLOC);
            end
            if (cmd.scan)
            begin
                if (scan_hit)
                begin
                    free_reg[found_idx] <= 1'b0;
                end
                else if (scan_last)
                begin
                    blank_reg <= 1'b1;
                end
                else
                begin
                    grp_reg <= grp_reg + GW'(1);
                end
            end
            if (cmd.finish && !blank_reg && (mode_reg == MODE_FREE))
            begin
                free_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg    <= mode;
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            tile_reg    <= tile;
            size_reg    <= size_word;
            addr_reg    <= slot_idx;
            granted_reg <= slot;
            status_reg  <= 1'b0;
        end
        if (cmd.scan)
        begin
            if (scan_hit)
            begin
                addr_reg    <= found_idx;
                granted_reg <= SLOT_W'(found_idx);
            end
            else if (scan_last)
            begin
                granted_reg <= '0;
                status_reg  <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            out_status_reg <= status_reg;
            out_slot_reg   <= granted_reg;
            word0_reg      <= blank_reg ? '0 : new0;
            word1_reg      <= blank_reg ? '0 : new1;
            word2_reg      <= blank_reg ? '0 : new2;
        end
    end

    assign status       = out_status_reg;
    assign granted_slot = out_slot_reg;
    assign word0        = word0_reg;
    assign word1        = word1_reg;
    assign word2        = word2_reg;

    a_alloc_marks_used: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && scan_hit) |=> !free_reg[addr_reg])
        else $error("allocated slot still marked free");

    a_free_marks_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !blank_reg && (mode_reg == MODE_FREE)) |=> free_reg[addr_reg])
        else $error("freed slot not marked free");

    a_blank_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && blank_reg) |=> ((word0_reg == '0) && (word1_reg == '0)
            && (word2_reg == '0)))
        else $error("blank result carries nonzero words");

endmodule

// ===== rtl/sprite_slot_table_manager_core.sv =====
// ----------------------------------------------------------------------------
// Sprite slot table manager
// Lowest-free slot allocator with a per-slot attribute table.
// ----------------------------------------------------------------------------
// Free, set, hide, show and read go from acceptance straight to the write-back
// stage, which presents the result. Allocate first scans the free map in
// 32-slot groups, from 1 up to ceil(SLOTS/32) of them, before its write-back.
// A new transaction is accepted only after the last has left write-back, which
// waits while an untaken result holds the output register.
// After reset the free map is all free at once, and a clearing pass writes
// every attribute memory entry; no transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
module sprite_slot_table_manager_core
    import sstm_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [SLOT_W-1:0] slot,
    input  logic [POSX_W-1:0] pos_x,
    input  logic [POSY_W-1:0] pos_y,
    input  logic [TILE_W-1:0] tile,
    input  logic [WORD_W-1:0] size_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [SLOT_W-1:0] granted_slot,
    output logic [WORD_W-1:0] word0,
    output logic [WORD_W-1:0] word1,
    output logic [WORD_W-1:0] word2
);

    sstm_cmd_t  cmd;
    sstm_stat_t stat;

    sstm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sstm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .tile         (tile),
        .size_word    (size_word),
        .status       (status),
        .granted_slot (granted_slot),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2)
    );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Sprite slot table manager testbench
// Drives allocate, free, set, hide, show, read and spare-mode requests
// through the valid/ready input channel with random gaps. A behavioral copy
// of the slot table predicts every result, and each result taken from the
// output channel is compared field by field. The random part fills the
// table until allocation is refused, then drains it and mixes all modes.
// A long output stall backs the block up against its input.
// ----------------------------------------------------------------------------
module tb;
    import sstm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = DEFAULT_SLOTS;
    localparam int RANDOM_REQUESTS = 600;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD_AT = 250;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
        logic [TILE_W-1:0] tile;
        logic [WORD_W-1:0] size_word;
        int unsigned       gap_after;
    } sprite_req_t;

    typedef struct {
        logic              status;
        logic [SLOT_W-1:0] granted_slot;
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
    } slot_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode = MODE_READ;
    logic [SLOT_W-1:0] slot = '0;
    logic [POSX_W-1:0] pos_x = '0;
    logic [POSY_W-1:0] pos_y = '0;
    logic [TILE_W-1:0] tile = '0;
    logic [WORD_W-1:0] size_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              status;
    logic [SLOT_W-1:0] granted_slot;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;

    sprite_req_t request_queue[$];
    slot_reply_t expected_replies[$];

    logic              slot_free[SLOTS];
    logic [WORD_W-1:0] shadow_attr0[SLOTS];
    logic [WORD_W-1:0] shadow_attr1[SLOTS];
    logic [WORD_W-1:0] shadow_attr2[SLOTS];

    int unsigned sender_wait = 0;
    int unsigned receiver_stall = 0;
    int unsigned replies_checked = 0;
    int unsigned allocs_granted = 0;
    int unsigned allocs_refused = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    bit          sender_burst = 1'b0;

    sprite_slot_table_manager_core #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .slot(slot),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .tile(tile),
        .size_word(size_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .granted_slot(granted_slot),
        .word0(word0),
        .word1(word1),
        .word2(word2)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic slot_reply_t predict_slot_op(sprite_req_t req);
        slot_reply_t reply;
        int          idx;
        bit          found;
        reply.status = 1'b0;
        reply.granted_slot = req.slot;
        reply.word0 = '0;
        reply.word1 = '0;
        reply.word2 = '0;
        if (req.mode == MODE_ALLOC)
        begin
            found = 1'b0;
            for (idx = 0; idx < SLOTS && !found; idx++)
            begin
                if (slot_free[idx])
                begin
                    found = 1'b1;
                    slot_free[idx] = 1'b0;
                    reply.granted_slot = idx[SLOT_W-1:0];
                    reply.word0 = shadow_attr0[idx];
                    reply.word1 = shadow_attr1[idx];
                    reply.word2 = shadow_attr2[idx];
                    allocs_granted++;
                end
            end
            if (!found)
            begin
                reply.status = 1'b1;
                reply.granted_slot = '0;
                allocs_refused++;
            end
            return reply;
        end
        if (int'(req.slot) >= SLOTS)
            return reply;
        idx = int'(req.slot);
        case (req.mode)
            MODE_FREE:
            begin
                slot_free[idx] = 1'b1;
                shadow_attr0[idx] = shadow_attr0[idx] | HIDE_BIT;
            end
            MODE_SET:
            begin
                shadow_attr0[idx] = {{(WORD_W-POSY_W){1'b0}}, req.pos_y};
                shadow_attr1[idx] = {{(WORD_W-POSX_W){1'b0}}, req.pos_x} | req.size_word;
                shadow_attr2[idx] = {{(WORD_W-TILE_W){1'b0}}, req.tile} | PRIO_ONE;
            end
            MODE_HIDE: shadow_attr0[idx] = shadow_attr0[idx] | HIDE_BIT;
            MODE_SHOW: shadow_attr0[idx] = shadow_attr0[idx] & ~HIDE_BIT;
            default: ;
        endcase
        reply.word0 = shadow_attr0[idx];
        reply.word1 = shadow_attr1[idx];
        reply.word2 = shadow_attr2[idx];
        return reply;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_request(input logic [MODE_W-1:0] op, input int unsigned idx,
                                 input int unsigned x, input int unsigned y,
                                 input int unsigned t, input int unsigned sz);
        sprite_req_t req;
        req.mode = op;
        req.slot = idx[SLOT_W-1:0];
        req.pos_x = x[POSX_W-1:0];
        req.pos_y = y[POSY_W-1:0];
        req.tile = t[TILE_W-1:0];
        req.size_word = sz[WORD_W-1:0];
        req.gap_after = sender_burst ? 0 : $urandom_range(0, 10);
        request_queue.push_back(req);
    endtask

    task automatic queue_random_request(input int unsigned alloc_pct,
                                        input int unsigned free_pct);
        int unsigned       roll;
        logic [MODE_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            op = MODE_ALLOC;
        else if (roll < alloc_pct + free_pct)
            op = MODE_FREE;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: op = MODE_SET;
                3, 4:    op = MODE_HIDE;
                5, 6:    op = MODE_SHOW;
                7:       op = MODE_READ;
                8:       op = MODE_SPARE_LO;
                default: op = MODE_SPARE_HI;
            endcase
        end
        queue_request(op, $urandom_range(0, 127), $urandom_range(0, 511),
                      $urandom_range(0, 255), $urandom_range(0, 1023),
                      $urandom_range(0, 65535));
    endtask

    initial
    begin
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_free[i] = 1'b1;
            shadow_attr0[i] = HIDE_BIT;
            shadow_attr1[i] = '0;
            shadow_attr2[i] = '0;
        end

        queue_request(MODE_READ, 0, 0, 0, 0, 0);
        queue_request(MODE_READ, 127, 511, 255, 1023, 16'hFFFF);
        queue_request(MODE_SPARE_LO, 5, 0, 0, 0, 0);
        queue_request(MODE_SPARE_HI, 127, 0, 0, 0, 0);
        queue_request(MODE_ALLOC, 0, 0, 0, 0, 0);
        queue_request(MODE_ALLOC, 0, 0, 0, 0, 0);
        queue_request(MODE_SET, 0, 511, 255, 1023, 16'hFFFF);
        queue_request(MODE_SET, 1, 0, 0, 0, 0);
        queue_request(MODE_HIDE, 0, 0, 0, 0, 0);
        queue_request(MODE_SHOW, 0, 0, 0, 0, 0);
        queue_request(MODE_SHOW, 127, 0, 0, 0, 0);
        queue_request(MODE_HIDE, 1, 0, 0, 0, 0);
        queue_request(MODE_FREE, 0, 0, 0, 0, 0);
        queue_request(MODE_FREE, 0, 0, 0, 0, 0);
        queue_request(MODE_ALLOC, 0, 0, 0, 0, 0);
        queue_request(MODE_SET, 127, 16'h155, 16'hAA, 16'h2AA, 16'h5555);
        queue_request(MODE_READ, 127, 0, 0, 0, 0);
        queue_request(MODE_SET, 64, 16'h0AA, 16'h55, 16'h155, 16'hAAAA);
        queue_request(MODE_SHOW, 64, 0, 0, 0, 0);
        queue_request(MODE_FREE, 127, 0, 0, 0, 0);
        queue_request(MODE_READ, 1, 0, 0, 0, 0);

        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            sender_burst = (i % 100) >= 70;
            if (i < 220)
                queue_random_request(80, 4);
            else if (i < 360)
                queue_random_request(10, 50);
            else
                queue_random_request(30, 20);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_replies.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d replies: %0d allocations granted, %0d refused on a full table.",
                 replies_checked, allocs_granted, allocs_refused);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        sprite_req_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_READ;
            slot <= '0;
            pos_x <= '0;
            pos_y <= '0;
            tile <= '0;
            size_word <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (sender_wait > 0)
            begin
                sender_wait--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                req = request_queue.pop_front();
                sender_wait = req.gap_after;
                in_valid <= 1'b1;
                mode <= req.mode;
                slot <= req.slot;
                pos_x <= req.pos_x;
                pos_y <= req.pos_y;
                tile <= req.tile;
                size_word <= req.size_word;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        sprite_req_t seen;
        slot_reply_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            receiver_stall = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen.mode = mode;
                seen.slot = slot;
                seen.pos_x = pos_x;
                seen.pos_y = pos_y;
                seen.tile = tile;
                seen.size_word = size_word;
                seen.gap_after = 0;
                expected_replies.push_back(predict_slot_op(seen));
            end
            if (out_valid && out_ready)
            begin
                replies_checked++;
                if (expected_replies.size() == 0)
                begin
                    $error("Reply received with no transaction outstanding.");
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("granted_slot", want.granted_slot, granted_slot);
                    compare_field("word0", want.word0, word0);
                    compare_field("word1", want.word1, word1);
                    compare_field("word2", want.word2, word2);
                end
                if (replies_checked == LONG_HOLD_AT)
                    receiver_stall = LONG_HOLD_CYCLES;
                else if ((replies_checked % 128) >= 96)
                    receiver_stall = 0;
                else
                    receiver_stall = $urandom_range(0, 10);
            end
            if (receiver_stall > 0)
            begin
                receiver_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timed out after %0d cycles without a transaction.", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
